// ===== design/wrdi_pkg.sv =====
// Types and constants shared by the weighted random delay injector.
package wrdi_pkg;

   typedef logic [3:0]  event_kind_type;
   typedef logic [63:0] context_id_type;
   typedef logic [1:0]  strength_type;
   typedef logic [1:0]  delay_kind_type;
   typedef logic [4:0]  delay_count_type;
   typedef logic [31:0] seed_type;
   typedef logic [15:0] rnd_type;
   typedef logic [9:0]  quot_type;
   typedef logic [6:0]  pct_type;

   localparam strength_type STR_NONE    = 2'd0;
   localparam strength_type STR_NORMAL  = 2'd1;
   localparam strength_type STR_ABOVE   = 2'd2;
   localparam strength_type STR_HIGHEST = 2'd3;

   localparam delay_kind_type KIND_NONE  = 2'd0;
   localparam delay_kind_type KIND_SPIN  = 2'd1;
   localparam delay_kind_type KIND_YIELD = 2'd2;
   localparam delay_kind_type KIND_SLEEP = 2'd3;

   localparam event_kind_type EV_ATOMIC_LO  = 4'd0;
   localparam event_kind_type EV_ATOMIC_HI  = 4'd2;
   localparam event_kind_type EV_UNLOCK     = 4'd3;
   localparam event_kind_type EV_THR_CREATE = 4'd4;
   localparam event_kind_type EV_THR_START  = 4'd5;
   localparam event_kind_type EV_LOCK_LO    = 4'd6;
   localparam event_kind_type EV_LOCK_HI    = 4'd9;
   localparam event_kind_type EV_COND_WAIT  = 4'd10;
   localparam event_kind_type EV_COND_TIMED = 4'd11;

   localparam seed_type SEED_RESET = 32'd1;
   localparam seed_type LCG_MUL    = 32'd1103515245;
   localparam seed_type LCG_ADD    = 32'd12345;

   localparam int unsigned RND_SHIFT = 16;
   // floor(x * 655 / 2^16) is x / 100 or one less for any 16-bit x
   localparam quot_type RECIP_100 = 10'd655;
   localparam pct_type  PCT_MOD   = 7'd100;

   typedef struct packed {
      strength_type    strength;
      delay_kind_type  delay_kind;
      delay_count_type delay_count;
   } result_type;

endpackage

// ===== design/wrdi_req_if.sv =====
// Input event channel.
interface wrdi_req_if;
   logic                     valid;
   logic                     ready;
   wrdi_pkg::event_kind_type event_kind;
   wrdi_pkg::context_id_type context_id;

   modport source (output valid, output event_kind, output context_id, input ready);
   modport sink (input valid, input event_kind, input context_id, output ready);
endinterface

// ===== design/wrdi_rsp_if.sv =====
// Result channel.
interface wrdi_rsp_if;
   logic                      valid;
   logic                      ready;
   wrdi_pkg::strength_type    strength;
   wrdi_pkg::delay_kind_type  delay_kind;
   wrdi_pkg::delay_count_type delay_count;

   modport source (output valid, output strength, output delay_kind, output delay_count,
                   input ready);
   modport sink (input valid, input strength, input delay_kind, input delay_count,
                 output ready);
endinterface

// ===== design/wrdi_csr_if.sv =====
// Seed register write channel.
interface wrdi_csr_if;
   logic               valid;
   logic               ready;
   wrdi_pkg::seed_type rng_seed;

   modport source (output valid, output rng_seed, input ready);
   modport sink (input valid, input rng_seed, output ready);
endinterface

// ===== design/wrdi_pick.sv =====
// Percent reduction and weight table walk that choose the delay.
module wrdi_pick (
   input  wrdi_pkg::strength_type strength,
   input  wrdi_pkg::rnd_type      rnd,
   input  wrdi_pkg::quot_type     quot,
   output wrdi_pkg::result_type   result
);

   logic [16:0]       quot_x100;
   logic [15:0]       rem_wide;
   logic [7:0]        rem_lo;
   wrdi_pkg::pct_type pct;
   wrdi_pkg::pct_type bound1;
   wrdi_pkg::pct_type bound2;
   wrdi_pkg::pct_type bound3;
   wrdi_pkg::pct_type span;

   always_comb begin
      quot_x100 = quot * wrdi_pkg::PCT_MOD;
      rem_wide  = rnd - quot_x100[15:0];
      rem_lo    = rem_wide[7:0];
      if (rem_lo >= {1'b0, wrdi_pkg::PCT_MOD}) begin
         rem_lo = rem_lo - {1'b0, wrdi_pkg::PCT_MOD};
      end
      pct = rem_lo[6:0];
   end

   always_comb begin
      case (strength)
         wrdi_pkg::STR_NORMAL: begin
            bound1 = 7'd95;
            bound2 = 7'd97;
            bound3 = 7'd99;
         end
         wrdi_pkg::STR_ABOVE: begin
            bound1 = 7'd80;
            bound2 = 7'd90;
            bound3 = 7'd97;
         end
         wrdi_pkg::STR_HIGHEST: begin
            bound1 = 7'd40;
            bound2 = 7'd60;
            bound3 = 7'd80;
         end
         default: begin
            bound1 = wrdi_pkg::PCT_MOD;
            bound2 = wrdi_pkg::PCT_MOD;
            bound3 = wrdi_pkg::PCT_MOD;
         end
      endcase
   end

   always_comb begin
      result.strength = strength;
      span            = '0;
      if (pct < bound1) begin
         result.delay_kind = wrdi_pkg::KIND_NONE;
      end else if (pct < bound2) begin
         result.delay_kind = wrdi_pkg::KIND_SPIN;
         span              = bound2 - pct;
      end else if (pct < bound3) begin
         result.delay_kind = wrdi_pkg::KIND_YIELD;
         span              = bound3 - pct;
      end else begin
         result.delay_kind = wrdi_pkg::KIND_SLEEP;
         span              = wrdi_pkg::PCT_MOD - pct;
      end
      result.delay_count = span[4:0];
   end

endmodule

// ===== design/weighted_random_delay_injector_unit.sv =====
// Weighted random delay injector: one result item per event, one event per clock cycle
// while rsp does not stall. Each accepted event is classified against the previous one
// at acceptance, where the generator also steps unless the strength is none (a zero
// state restarts from rng_seed); the strength and the upper half of the new state pass a
// reciprocal stage and a percent/table stage, held in s1, s2 and the result register.
// The generator state and the last event are updated in the accepting cycle; the 32-bit
// constant multiply of that step sets the cycle time. Each stage holds while its
// successor is full, so stalls on rsp back up one stage at a time. rng_seed is written
// through csr, which is always ready, and resets to 1.
module weighted_random_delay_injector_unit (
   input  logic       clock,
   input  logic       reset,
   wrdi_req_if.sink   req,
   wrdi_rsp_if.source rsp,
   wrdi_csr_if.sink   csr
);

   wrdi_pkg::seed_type       rng_seed_ff;
   wrdi_pkg::seed_type       lcg_state_ff;
   wrdi_pkg::seed_type       lcg_state_in;
   wrdi_pkg::event_kind_type last_event_ff;
   wrdi_pkg::context_id_type last_context_ff;
   logic                     last_valid_ff;

   logic                     s1_valid_ff;
   wrdi_pkg::strength_type   s1_strength_ff;
   wrdi_pkg::rnd_type        s1_rnd_ff;
   logic                     s2_valid_ff;
   wrdi_pkg::strength_type   s2_strength_ff;
   wrdi_pkg::rnd_type        s2_rnd_ff;
   wrdi_pkg::quot_type       s2_quot_ff;
   logic                     rsp_valid_ff;
   wrdi_pkg::result_type     rsp_result_ff;
   wrdi_pkg::result_type     rsp_result_in;

   logic                     s1_ready;
   logic                     s2_ready;
   logic                     out_ready;
   logic                     accept;
   logic                     prev_cond;
   logic                     same_ctx;
   wrdi_pkg::strength_type   strength_in;
   wrdi_pkg::seed_type       lcg_base;
   logic [25:0]              quot_prod;

   assign out_ready = !rsp_valid_ff || rsp.ready;
   assign s2_ready  = !s2_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;
   assign accept    = req.valid && s1_ready;
   assign csr.ready = 1'b1;

   always_comb begin
      prev_cond = last_valid_ff && ((last_event_ff == wrdi_pkg::EV_COND_WAIT) ||
                                    (last_event_ff == wrdi_pkg::EV_COND_TIMED));
      same_ctx  = last_valid_ff && (last_context_ff == req.context_id);
      if (req.event_kind inside {[wrdi_pkg::EV_ATOMIC_LO:wrdi_pkg::EV_ATOMIC_HI]}) begin
         strength_in = wrdi_pkg::STR_ABOVE;
      end else if (req.event_kind == wrdi_pkg::EV_UNLOCK) begin
         strength_in = wrdi_pkg::STR_NONE;
      end else if (req.event_kind inside {wrdi_pkg::EV_THR_CREATE,
                                          wrdi_pkg::EV_THR_START}) begin
         strength_in = wrdi_pkg::STR_HIGHEST;
      end else if (req.event_kind inside {[wrdi_pkg::EV_LOCK_LO:wrdi_pkg::EV_LOCK_HI]}) begin
         if (prev_cond) begin
            strength_in = wrdi_pkg::STR_NONE;
         end else if (same_ctx) begin
            strength_in = wrdi_pkg::STR_ABOVE;
         end else begin
            strength_in = wrdi_pkg::STR_NORMAL;
         end
      end else if (req.event_kind inside {wrdi_pkg::EV_COND_WAIT,
                                          wrdi_pkg::EV_COND_TIMED}) begin
         strength_in = wrdi_pkg::STR_ABOVE;
      end else begin
         strength_in = wrdi_pkg::STR_NORMAL;
      end
   end

   always_comb begin
      lcg_base     = (lcg_state_ff == '0) ? rng_seed_ff : lcg_state_ff;
      lcg_state_in = lcg_base * wrdi_pkg::LCG_MUL + wrdi_pkg::LCG_ADD;
      quot_prod    = s1_rnd_ff * wrdi_pkg::RECIP_100;
   end

   wrdi_pick u_pick (
      .strength (s2_strength_ff),
      .rnd      (s2_rnd_ff),
      .quot     (s2_quot_ff),
      .result   (rsp_result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rng_seed_ff     <= wrdi_pkg::SEED_RESET;
         lcg_state_ff    <= '0;
         last_event_ff   <= '0;
         last_context_ff <= '0;
         last_valid_ff   <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr.valid) begin
            rng_seed_ff <= csr.rng_seed;
         end
         if (accept) begin
            last_event_ff   <= req.event_kind;
            last_context_ff <= req.context_id;
            last_valid_ff   <= 1'b1;
            if (strength_in != wrdi_pkg::STR_NONE) begin
               lcg_state_ff <= lcg_state_in;
            end
         end
         if (s1_ready) begin
            s1_valid_ff <= accept;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_strength_ff <= strength_in;
         s1_rnd_ff      <= lcg_state_in[wrdi_pkg::RND_SHIFT +: 16];
      end
      if (s2_ready && s1_valid_ff) begin
         s2_strength_ff <= s1_strength_ff;
         s2_rnd_ff      <= s1_rnd_ff;
         s2_quot_ff     <= quot_prod[25:16];
      end
      if (out_ready && s2_valid_ff) begin
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.strength    = rsp_result_ff.strength;
   assign rsp.delay_kind  = rsp_result_ff.delay_kind;
   assign rsp.delay_count = rsp_result_ff.delay_count;

endmodule

// ===== design/wrdi_checker.sv =====
// Port-level checks for the delay injector, bound to the top level.
module wrdi_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input wrdi_pkg::strength_type    rsp_strength,
   input wrdi_pkg::delay_kind_type  rsp_delay_kind,
   input wrdi_pkg::delay_count_type rsp_delay_count
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_strength) &&
         $stable(rsp_delay_kind) && $stable(rsp_delay_count))
      else $error("stalled result item changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_strength == wrdi_pkg::STR_NONE) |->
         (rsp_delay_kind == wrdi_pkg::KIND_NONE) && (rsp_delay_count == '0))
      else $error("delay chosen for strength none");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_delay_kind == wrdi_pkg::KIND_NONE) == (rsp_delay_count == '0)) &&
         (rsp_delay_count <= 5'd20))
      else $error("delay count inconsistent with delay kind");

endmodule

bind weighted_random_delay_injector_unit wrdi_checker u_wrdi_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_strength    (rsp.strength),
   .rsp_delay_kind  (rsp.delay_kind),
   .rsp_delay_count (rsp.delay_count)
);
